// ===== rtl/core/vfld_pkg.sv =====
// Shared constants, codes and types of the video frame lag dropper.
`timescale 1ns / 1ps

package vfld_pkg;

    // Time arithmetic width; sums and differences wrap here, compares are signed
    localparam int TIME_BITS      = 48;
    localparam int COUNT_BITS     = 32;
    localparam int ARRIVAL_BITS   = 47;
    localparam int STAMP_BITS     = 48;
    localparam int LIMIT_BITS     = 16;
    localparam int NUM_BITS       = 16;
    localparam int DEN_BITS       = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int MS_PER_S       = 1000;

    // Timestamp conversion datapath
    localparam int SCALE_BITS = 26;                       // 1000 * 65535 fits
    localparam int HALF_BITS  = STAMP_BITS / 2;
    localparam int PART_BITS  = HALF_BITS + SCALE_BITS;
    localparam int PROD_BITS  = STAMP_BITS + SCALE_BITS;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int DIV_STEPS  = STAMP_BITS / 2;           // two quotient bits a cycle
    localparam int STEP_BITS  = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [LIMIT_BITS-1:0] RENDER_LAG_RESET = LIMIT_BITS'(300);
    localparam logic [LIMIT_BITS-1:0] RESET_LAG_RESET  = LIMIT_BITS'(5000);
    localparam logic [LIMIT_BITS-1:0] WARMUP_RESET     = LIMIT_BITS'(2000);
    localparam logic [NUM_BITS-1:0]   TB_NUM_RESET     = NUM_BITS'(1);
    localparam logic [DEN_BITS-1:0]   TB_DEN_RESET     = DEN_BITS'(90000);

    typedef enum logic [1:0] {
        CMD_FRAME    = 2'd0,
        CMD_CONSUMED = 2'd1,
        CMD_START    = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_RENDER    = 3'd0,
        ACT_DROP_LATE = 3'd1,
        ACT_DROP_BUSY = 3'd2,
        ACT_FLUSH     = 3'd3,
        ACT_NONE      = 3'd4
    } action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RENDER_LAG = 3'd0,
        CFG_RESET_LAG  = 3'd1,
        CFG_WARMUP     = 3'd2,
        CFG_TB_NUM     = 3'd3,
        CFG_TB_DEN     = 3'd4
    } cfg_idx_t;

    // Work class decided by the front
    typedef enum logic [2:0] {
        KIND_STAMPED,
        KIND_BARE,
        KIND_CONSUMED,
        KIND_START,
        KIND_IGNORE
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ARRIVAL_BITS-1:0] arrival_ms;
        logic [STAMP_BITS-1:0]   raw_stamp;
    } item_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] render_lag_limit_ms;
        logic [LIMIT_BITS-1:0] reset_lag_limit_ms;
        logic [LIMIT_BITS-1:0] warmup_window_ms;
        logic [NUM_BITS-1:0]   timebase_numerator;
        logic [DEN_BITS-1:0]   timebase_denominator;
    } cfg_t;

    // Handshake between queue and back
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_REBASE,
        ST_SUM,
        ST_LAG,
        ST_DECIDE
    } back_state_t;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_MUL_LO,
        CV_MUL_HI,
        CV_DIV_INIT,
        CV_DIV,
        CV_SAT
    } conv_state_t;

endpackage

// ===== rtl/core/vfld_front.sv =====
// Front end: accept transactions, classify them and queue them for the back end.
`timescale 1ns / 1ps

module vfld_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic [vfld_pkg::ARRIVAL_BITS-1:0]     arrival_ms,
    input  logic                                  stamp_valid,
    input  logic signed [vfld_pkg::STAMP_BITS-1:0] raw_stamp,
    output vfld_pkg::queue_out_t                  q_out,
    input  logic                                  pop
);

    vfld_pkg::item_t                    entry_reg [vfld_pkg::QUEUE_DEPTH];
    logic [vfld_pkg::QPTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [vfld_pkg::QPTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [vfld_pkg::QCNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                               push;
    vfld_pkg::item_t                    new_item;

    assign in_ready = (cnt_reg < vfld_pkg::QCNT_BITS'(vfld_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    // Classify the incoming transaction
    always_comb
    begin
        new_item.arrival_ms = arrival_ms;
        new_item.raw_stamp  = raw_stamp;
        unique case (vfld_pkg::cmd_t'(command))
            vfld_pkg::CMD_FRAME:
                new_item.kind = stamp_valid ? vfld_pkg::KIND_STAMPED : vfld_pkg::KIND_BARE;
            vfld_pkg::CMD_CONSUMED: new_item.kind = vfld_pkg::KIND_CONSUMED;
            vfld_pkg::CMD_START:    new_item.kind = vfld_pkg::KIND_START;
            default:                new_item.kind = vfld_pkg::KIND_IGNORE;
        endcase
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vfld_pkg::QPTR_BITS'(vfld_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vfld_pkg::QPTR_BITS'(vfld_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign q_out.valid = (cnt_reg != '0);
    assign q_out.item  = entry_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= vfld_pkg::QCNT_BITS'(vfld_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/vfld_conv.sv =====
// Timestamp converter: raw stamp * 1000 * num / den in ms, iterative, saturating.
`timescale 1ns / 1ps

module vfld_conv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [vfld_pkg::STAMP_BITS-1:0]    raw_stamp,
    input  vfld_pkg::cfg_t                     cfg,
    output logic                               done,
    output logic [vfld_pkg::TIME_BITS-1:0]     pts_ms
);

    localparam int SB = vfld_pkg::STAMP_BITS;
    localparam int TB = vfld_pkg::TIME_BITS;

    vfld_pkg::conv_state_t              state_reg, state_next;
    logic                               neg_reg, neg_next;
    logic [SB-1:0]                      mag_reg, mag_next;
    logic [vfld_pkg::SCALE_BITS-1:0]    k_reg, k_next;
    logic [vfld_pkg::DEN_BITS-1:0]      den_reg, den_next;
    logic [vfld_pkg::PROD_BITS-1:0]     prod_reg, prod_next;
    logic [vfld_pkg::REM_BITS-1:0]      rem_reg, rem_next;
    logic [SB-1:0]                      quo_reg, quo_next;
    logic [vfld_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic                               over_reg, over_next;
    logic [TB-1:0]                      pts_reg, pts_next;
    logic                               done_reg, done_next;

    logic [vfld_pkg::HALF_BITS-1:0]     mul_a;
    logic [vfld_pkg::PART_BITS-1:0]     part_prod;
    logic [vfld_pkg::REM_BITS-1:0]      den_ext;
    logic [vfld_pkg::REM_BITS-1:0]      r1, r1s, r2, r2s;
    logic                               q1, q2;
    logic [SB-1:0]                      mag_in;

    assign mag_in = raw_stamp[SB-1] ? (~raw_stamp + 1'b1) : raw_stamp;

    // One shared multiplier for both halves of the magnitude
    assign mul_a     = (state_reg == vfld_pkg::CV_MUL_LO)
                       ? mag_reg[vfld_pkg::HALF_BITS-1:0]
                       : mag_reg[SB-1:vfld_pkg::HALF_BITS];
    assign part_prod = vfld_pkg::PART_BITS'(mul_a) * vfld_pkg::PART_BITS'(k_reg);

    // Two restoring division steps per cycle
    assign den_ext = vfld_pkg::REM_BITS'(den_reg);
    assign r1  = {rem_reg[vfld_pkg::DEN_BITS-1:0], prod_reg[SB-1]};
    assign q1  = (r1 >= den_ext);
    assign r1s = q1 ? (r1 - den_ext) : r1;
    assign r2  = {r1s[vfld_pkg::DEN_BITS-1:0], prod_reg[SB-2]};
    assign q2  = (r2 >= den_ext);
    assign r2s = q2 ? (r2 - den_ext) : r2;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        k_next     = k_reg;
        den_next   = den_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        over_next  = over_reg;
        pts_next   = pts_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            vfld_pkg::CV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = raw_stamp[SB-1];
                    mag_next   = mag_in;
                    k_next     = vfld_pkg::SCALE_BITS'(cfg.timebase_numerator)
                                 * vfld_pkg::SCALE_BITS'(vfld_pkg::MS_PER_S);
                    // Zero denominator counts as one
                    den_next   = (cfg.timebase_denominator == '0)
                                 ? vfld_pkg::DEN_BITS'(1) : cfg.timebase_denominator;
                    state_next = vfld_pkg::CV_MUL_LO;
                end
            end
            vfld_pkg::CV_MUL_LO:
            begin
                prod_next  = vfld_pkg::PROD_BITS'(part_prod);
                state_next = vfld_pkg::CV_MUL_HI;
            end
            vfld_pkg::CV_MUL_HI:
            begin
                prod_next  = prod_reg
                             + (vfld_pkg::PROD_BITS'(part_prod) << vfld_pkg::HALF_BITS);
                state_next = vfld_pkg::CV_DIV_INIT;
            end
            vfld_pkg::CV_DIV_INIT:
            begin
                // Quotient reaches 2^48 exactly when the top part is not below den
                rem_next   = vfld_pkg::REM_BITS'(prod_reg[vfld_pkg::PROD_BITS-1:SB]);
                over_next  = (vfld_pkg::REM_BITS'(prod_reg[vfld_pkg::PROD_BITS-1:SB])
                              >= den_ext);
                quo_next   = '0;
                step_next  = '0;
                state_next = vfld_pkg::CV_DIV;
            end
            vfld_pkg::CV_DIV:
            begin
                rem_next  = r2s;
                quo_next  = {quo_reg[SB-3:0], q1, q2};
                prod_next = {prod_reg[vfld_pkg::PROD_BITS-1:SB], prod_reg[SB-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == vfld_pkg::STEP_BITS'(vfld_pkg::DIV_STEPS - 1))
                begin
                    state_next = vfld_pkg::CV_SAT;
                end
            end
            vfld_pkg::CV_SAT:
            begin
                // Clamp to the signed time range
                if (neg_reg)
                begin
                    if (over_reg || (quo_reg > {1'b1, {(SB-1){1'b0}}}))
                    begin
                        pts_next = {1'b1, {(TB-1){1'b0}}};
                    end
                    else
                    begin
                        pts_next = TB'(~quo_reg + 1'b1);
                    end
                end
                else
                begin
                    if (over_reg || quo_reg[SB-1])
                    begin
                        pts_next = {1'b0, {(TB-1){1'b1}}};
                    end
                    else
                    begin
                        pts_next = TB'(quo_reg);
                    end
                end
                done_next  = 1'b1;
                state_next = vfld_pkg::CV_IDLE;
            end
            default:
            begin
                state_next = vfld_pkg::CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vfld_pkg::CV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        k_reg    <= k_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        over_reg <= over_next;
        pts_reg  <= pts_next;
    end

    assign done   = done_reg;
    assign pts_ms = pts_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == vfld_pkg::CV_IDLE))
        else $error("conversion started while busy");
`endif

endmodule

// ===== rtl/core/vfld_back.sv =====
// Back end: reference tracking, lag measurement, frame decision and result register.
`timescale 1ns / 1ps

module vfld_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  vfld_pkg::cfg_t                         cfg,
    input  vfld_pkg::queue_out_t                   q_out,
    output logic                                   pop,
    output logic                                   conv_start,
    output logic [vfld_pkg::STAMP_BITS-1:0]        conv_raw,
    input  logic                                   conv_done,
    input  logic [vfld_pkg::TIME_BITS-1:0]         conv_pts,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             action,
    output logic [vfld_pkg::ARRIVAL_BITS-1:0]      lag_ms,
    output logic signed [vfld_pkg::STAMP_BITS-1:0] stamp_ms,
    output logic [vfld_pkg::COUNT_BITS-1:0]        late_drops,
    output logic [vfld_pkg::COUNT_BITS-1:0]        busy_drops
);

    localparam int TB = vfld_pkg::TIME_BITS;
    localparam int CB = vfld_pkg::COUNT_BITS;
    localparam int AB = vfld_pkg::ARRIVAL_BITS;

    vfld_pkg::back_state_t  state_reg, state_next;
    vfld_pkg::item_t        item_reg, item_next;
    logic [TB-1:0]          pts_reg, pts_next;
    logic [TB-1:0]          d_reg, d_next;
    logic [TB-1:0]          exp_reg, exp_next;
    logic [AB-1:0]          lag_reg, lag_next;

    // Session state
    logic [TB-1:0]          ref_stamp_reg, ref_stamp_next;
    logic [TB-1:0]          ref_wall_reg, ref_wall_next;
    logic [TB-1:0]          warmup_end_reg, warmup_end_next;
    logic [TB-1:0]          last_stamp_reg, last_stamp_next;
    logic                   disp_busy_reg, disp_busy_next;
    logic [CB-1:0]          late_cnt_reg, late_cnt_next;
    logic [CB-1:0]          busy_cnt_reg, busy_cnt_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    vfld_pkg::action_t      action_reg, action_next;
    logic [AB-1:0]          lag_out_reg, lag_out_next;
    logic [TB-1:0]          stamp_out_reg, stamp_out_next;
    logic [CB-1:0]          late_out_reg, late_out_next;
    logic [CB-1:0]          busy_out_reg, busy_out_next;

    logic [TB-1:0]          now_ext;
    logic                   rebase;
    logic [TB-1:0]          diff;
    logic                   out_free;
    logic                   restart;
    vfld_pkg::action_t      act;

    assign now_ext  = TB'(item_reg.arrival_ms);
    assign rebase   = ref_stamp_reg[TB-1] || ($signed(pts_reg) < $signed(ref_stamp_reg));
    assign diff     = now_ext - exp_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign conv_raw = q_out.item.raw_stamp;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        pts_next        = pts_reg;
        d_next          = d_reg;
        exp_next        = exp_reg;
        lag_next        = lag_reg;
        ref_stamp_next  = ref_stamp_reg;
        ref_wall_next   = ref_wall_reg;
        warmup_end_next = warmup_end_reg;
        last_stamp_next = last_stamp_reg;
        disp_busy_next  = disp_busy_reg;
        late_cnt_next   = late_cnt_reg;
        busy_cnt_next   = busy_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        action_next     = action_reg;
        lag_out_next    = lag_out_reg;
        stamp_out_next  = stamp_out_reg;
        late_out_next   = late_out_reg;
        busy_out_next   = busy_out_reg;
        pop             = 1'b0;
        conv_start      = 1'b0;
        restart         = 1'b0;
        act             = vfld_pkg::ACT_NONE;

        unique case (state_reg)
            vfld_pkg::ST_IDLE:
            begin
                // Take the next queued transaction
                if (q_out.valid)
                begin
                    pop       = 1'b1;
                    item_next = q_out.item;
                    if (q_out.item.kind == vfld_pkg::KIND_STAMPED)
                    begin
                        conv_start = 1'b1;
                        state_next = vfld_pkg::ST_CONVERT;
                    end
                    else
                    begin
                        lag_next   = '0;
                        state_next = vfld_pkg::ST_DECIDE;
                    end
                end
            end
            vfld_pkg::ST_CONVERT:
            begin
                if (conv_done)
                begin
                    pts_next   = conv_pts;
                    state_next = vfld_pkg::ST_REBASE;
                end
            end
            vfld_pkg::ST_REBASE:
            begin
                // Rebase on unset reference or backward time; arm warm-up once
                last_stamp_next = pts_reg;
                if (rebase)
                begin
                    ref_stamp_next = pts_reg;
                    ref_wall_next  = now_ext;
                    if (warmup_end_reg == '0)
                    begin
                        warmup_end_next = now_ext + TB'(cfg.warmup_window_ms);
                    end
                end
                d_next     = rebase ? '0 : (pts_reg - ref_stamp_reg);
                state_next = vfld_pkg::ST_SUM;
            end
            vfld_pkg::ST_SUM:
            begin
                exp_next   = ref_wall_reg + d_reg;
                state_next = vfld_pkg::ST_LAG;
            end
            vfld_pkg::ST_LAG:
            begin
                if ($signed(now_ext) < $signed(warmup_end_reg))
                begin
                    // Warm-up: reference follows every frame
                    ref_stamp_next = pts_reg;
                    ref_wall_next  = now_ext;
                    lag_next       = '0;
                end
                else if (diff[TB-1])
                begin
                    // Early arrival: pull the reference earlier
                    ref_wall_next = ref_wall_reg + diff;
                    lag_next      = '0;
                end
                else
                begin
                    lag_next = AB'(diff);
                end
                state_next = vfld_pkg::ST_DECIDE;
            end
            vfld_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    unique case (item_reg.kind)
                        vfld_pkg::KIND_CONSUMED:
                        begin
                            disp_busy_next = 1'b0;
                        end
                        vfld_pkg::KIND_START:
                        begin
                            // Session start answers with the cleared counters
                            restart       = 1'b1;
                            late_cnt_next = '0;
                            busy_cnt_next = '0;
                        end
                        vfld_pkg::KIND_STAMPED, vfld_pkg::KIND_BARE:
                        begin
                            priority if (lag_reg > AB'(cfg.reset_lag_limit_ms))
                            begin
                                act     = vfld_pkg::ACT_FLUSH;
                                restart = 1'b1;
                            end
                            else if (lag_reg > AB'(cfg.render_lag_limit_ms))
                            begin
                                act = vfld_pkg::ACT_DROP_LATE;
                                if (late_cnt_reg != '1)
                                begin
                                    late_cnt_next = late_cnt_reg + 1'b1;
                                end
                            end
                            else if (disp_busy_reg)
                            begin
                                act = vfld_pkg::ACT_DROP_BUSY;
                                if (busy_cnt_reg != '1)
                                begin
                                    busy_cnt_next = busy_cnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                act            = vfld_pkg::ACT_RENDER;
                                disp_busy_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            act = vfld_pkg::ACT_NONE;
                        end
                    endcase

                    // Load the result with the counters of this session
                    out_valid_next = 1'b1;
                    action_next    = act;
                    lag_out_next   = lag_reg;
                    stamp_out_next = last_stamp_reg;
                    late_out_next  = late_cnt_next;
                    busy_out_next  = busy_cnt_next;

                    // Drop the session on flush or start
                    if (restart)
                    begin
                        disp_busy_next  = 1'b0;
                        ref_stamp_next  = '1;
                        ref_wall_next   = '0;
                        warmup_end_next = '0;
                        late_cnt_next   = '0;
                        busy_cnt_next   = '0;
                    end
                    state_next = vfld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfld_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vfld_pkg::ST_IDLE;
            ref_stamp_reg  <= '1;
            ref_wall_reg   <= '0;
            warmup_end_reg <= '0;
            last_stamp_reg <= '0;
            disp_busy_reg  <= 1'b0;
            late_cnt_reg   <= '0;
            busy_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ref_stamp_reg  <= ref_stamp_next;
            ref_wall_reg   <= ref_wall_next;
            warmup_end_reg <= warmup_end_next;
            last_stamp_reg <= last_stamp_next;
            disp_busy_reg  <= disp_busy_next;
            late_cnt_reg   <= late_cnt_next;
            busy_cnt_reg   <= busy_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pts_reg       <= pts_next;
        d_reg         <= d_next;
        exp_reg       <= exp_next;
        lag_reg       <= lag_next;
        action_reg    <= action_next;
        lag_out_reg   <= lag_out_next;
        stamp_out_reg <= stamp_out_next;
        late_out_reg  <= late_out_next;
        busy_out_reg  <= busy_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign lag_ms     = lag_out_reg;
    assign stamp_ms   = stamp_out_reg;
    assign late_drops = late_out_reg;
    assign busy_drops = busy_out_reg;

`ifndef SYNTHESIS
    a_load_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == vfld_pkg::ST_DECIDE))
        else $error("result loaded outside decision step");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == vfld_pkg::ST_CONVERT))
        else $error("conversion finished while not waiting for it");
`endif

endmodule

// ===== rtl/core/video_frame_lag_dropper_unit.sv =====
// Video frame lag dropper: configuration registers, front queue, converter and back end.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, arrival_ms, stamp_valid
//   and raw_stamp. Every transaction yields exactly one result on the output
//   channel (out_valid/out_ready): action, lag_ms, stamp_ms, late_drops and
//   busy_drops. Configuration is written through cfg_we/cfg_index/cfg_data
//   while the block is idle; indexes beyond the register list are ignored.
//   A stamped frame passes from acceptance to out_valid through dequeue,
//   two multiply steps, one setup step, 24 divide steps (two bits a
//   cycle), clamp, handover, then rebase, sum, lag and decide. Other
//   transactions go from dequeue straight to decide. The back end takes
//   one transaction at a time; a two-entry queue in front lets the sender
//   hand over transactions while the back end is busy.
//   Reset: configuration returns to 300/5000/2000 ms, time base 1/90000;
//   the session is cleared and the reference is unset.
//   Receiver stall: the result register holds until taken; the back end
//   waits in its decision step and the queue fills, then in_ready drops.
`timescale 1ns / 1ps

module video_frame_lag_dropper_unit (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [vfld_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [vfld_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [1:0]                                 command,
    input  logic [vfld_pkg::ARRIVAL_BITS-1:0]          arrival_ms,
    input  logic                                       stamp_valid,
    input  logic signed [vfld_pkg::STAMP_BITS-1:0]     raw_stamp,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [2:0]                                 action,
    output logic [vfld_pkg::ARRIVAL_BITS-1:0]          lag_ms,
    output logic signed [vfld_pkg::STAMP_BITS-1:0]     stamp_ms,
    output logic [vfld_pkg::COUNT_BITS-1:0]            late_drops,
    output logic [vfld_pkg::COUNT_BITS-1:0]            busy_drops
);

    vfld_pkg::cfg_t                          cfg_reg;
    vfld_pkg::queue_out_t                    q_out;
    logic                                    pop;
    logic                                    conv_start;
    logic [vfld_pkg::STAMP_BITS-1:0]         conv_raw;
    logic                                    conv_done;
    logic [vfld_pkg::TIME_BITS-1:0]          conv_pts;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.render_lag_limit_ms  <= vfld_pkg::RENDER_LAG_RESET;
            cfg_reg.reset_lag_limit_ms   <= vfld_pkg::RESET_LAG_RESET;
            cfg_reg.warmup_window_ms     <= vfld_pkg::WARMUP_RESET;
            cfg_reg.timebase_numerator   <= vfld_pkg::TB_NUM_RESET;
            cfg_reg.timebase_denominator <= vfld_pkg::TB_DEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (vfld_pkg::cfg_idx_t'(cfg_index))
                vfld_pkg::CFG_RENDER_LAG:
                    cfg_reg.render_lag_limit_ms <= cfg_data[vfld_pkg::LIMIT_BITS-1:0];
                vfld_pkg::CFG_RESET_LAG:
                    cfg_reg.reset_lag_limit_ms <= cfg_data[vfld_pkg::LIMIT_BITS-1:0];
                vfld_pkg::CFG_WARMUP:
                    cfg_reg.warmup_window_ms <= cfg_data[vfld_pkg::LIMIT_BITS-1:0];
                vfld_pkg::CFG_TB_NUM:
                    cfg_reg.timebase_numerator <= cfg_data[vfld_pkg::NUM_BITS-1:0];
                vfld_pkg::CFG_TB_DEN:
                    cfg_reg.timebase_denominator <= cfg_data[vfld_pkg::DEN_BITS-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    vfld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .arrival_ms  (arrival_ms),
        .stamp_valid (stamp_valid),
        .raw_stamp   (raw_stamp),
        .q_out       (q_out),
        .pop         (pop)
    );

    vfld_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (conv_start),
        .raw_stamp (conv_raw),
        .cfg       (cfg_reg),
        .done      (conv_done),
        .pts_ms    (conv_pts)
    );

    vfld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_out      (q_out),
        .pop        (pop),
        .conv_start (conv_start),
        .conv_raw   (conv_raw),
        .conv_done  (conv_done),
        .conv_pts   (conv_pts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .action     (action),
        .lag_ms     (lag_ms),
        .stamp_ms   (stamp_ms),
        .late_drops (late_drops),
        .busy_drops (busy_drops)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the video frame lag dropper unit.
`timescale 1ns / 1ps

module tb_top;

    import vfld_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = 64;
    localparam int FRAME_PERIOD   = 33;

    localparam logic [TIME_BITS-1:0] NEG_BOUND_MAG = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam logic [TIME_BITS-1:0] POS_BOUND     = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic [STAMP_BITS-1:0] STAMP_MAX    = {1'b0, {(STAMP_BITS-1){1'b1}}};
    localparam logic [STAMP_BITS-1:0] STAMP_MIN    = {1'b1, {(STAMP_BITS-1){1'b0}}};
    localparam logic [ARRIVAL_BITS-1:0] ARRIVAL_MAX = '1;

    typedef struct {
        action_t                 act;
        logic [ARRIVAL_BITS-1:0] lag;
        logic [STAMP_BITS-1:0]   stamp;
        logic [COUNT_BITS-1:0]   late;
        logic [COUNT_BITS-1:0]   busy;
    } frame_fate_t;

    // DUT ports
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command = '0;
    logic [ARRIVAL_BITS-1:0]    arrival_ms = '0;
    logic                       stamp_valid = 1'b0;
    logic signed [STAMP_BITS-1:0] raw_stamp = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [2:0]                 action;
    logic [ARRIVAL_BITS-1:0]    lag_ms;
    logic signed [STAMP_BITS-1:0] stamp_ms;
    logic [COUNT_BITS-1:0]      late_drops;
    logic [COUNT_BITS-1:0]      busy_drops;

    // Predictor copy of the configuration
    logic [LIMIT_BITS-1:0] cfg_render = RENDER_LAG_RESET;
    logic [LIMIT_BITS-1:0] cfg_reset  = RESET_LAG_RESET;
    logic [LIMIT_BITS-1:0] cfg_warm   = WARMUP_RESET;
    logic [NUM_BITS-1:0]   cfg_num    = TB_NUM_RESET;
    logic [DEN_BITS-1:0]   cfg_den    = TB_DEN_RESET;

    // Predictor copy of the session state
    logic [TIME_BITS-1:0]  anchor_stamp;
    logic [TIME_BITS-1:0]  anchor_wall;
    logic [TIME_BITS-1:0]  warm_end;
    logic [TIME_BITS-1:0]  last_stamp = '0;
    logic                  display_taken;
    logic [COUNT_BITS-1:0] late_cnt;
    logic [COUNT_BITS-1:0] busy_cnt;

    frame_fate_t expected_fates[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    longint      stream_wall;
    longint      stream_raw;

    video_frame_lag_dropper_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .arrival_ms  (arrival_ms),
        .stamp_valid (stamp_valid),
        .raw_stamp   (raw_stamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .lag_ms      (lag_ms),
        .stamp_ms    (stamp_ms),
        .late_drops  (late_drops),
        .busy_drops  (busy_drops)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the session: reference unset, warm-up disarmed, counters zero
    function automatic void restart_session();
        display_taken = 1'b0;
        anchor_stamp  = '1;
        anchor_wall   = '0;
        warm_end      = '0;
        late_cnt      = '0;
        busy_cnt      = '0;
    endfunction

    // Convert a raw timestamp to ms, truncating toward zero and saturating
    function automatic logic [TIME_BITS-1:0] stamp_to_ms(logic [STAMP_BITS-1:0] raw);
        logic                 neg;
        logic [TIME_BITS-1:0] mag;
        logic [127:0]         prod;
        logic [127:0]         quo;
        logic [DEN_BITS-1:0]  den;
        neg  = raw[STAMP_BITS-1];
        mag  = neg ? -raw : raw;
        den  = (cfg_den == '0) ? DEN_BITS'(1) : cfg_den;
        prod = 128'(mag) * 128'(cfg_num) * 128'(MS_PER_S);
        quo  = prod / 128'(den);
        if (neg)
        begin
            if (quo > 128'(NEG_BOUND_MAG))
                quo = 128'(NEG_BOUND_MAG);
            return -(quo[TIME_BITS-1:0]);
        end
        if (quo > 128'(POS_BOUND))
            quo = 128'(POS_BOUND);
        return quo[TIME_BITS-1:0];
    endfunction

    // Work out the fate of one transaction and advance the predictor state
    function automatic frame_fate_t predict_frame_fate(cmd_t cmd,
                                                       logic [ARRIVAL_BITS-1:0] arr,
                                                       logic has_stamp,
                                                       logic [STAMP_BITS-1:0] raw);
        frame_fate_t          fate;
        logic [TIME_BITS-1:0] wall_now;
        logic [TIME_BITS-1:0] pts;
        logic [TIME_BITS-1:0] lag;
        logic                 flush;
        wall_now = TIME_BITS'(arr);
        lag      = '0;
        flush    = 1'b0;
        fate.act = ACT_NONE;
        case (cmd)
            CMD_CONSUMED:
                display_taken = 1'b0;
            CMD_START:
                restart_session();
            CMD_FRAME:
            begin
                if (has_stamp)
                begin
                    pts = stamp_to_ms(raw);
                    last_stamp = pts;
                    // Rebase when unset or when time runs backward
                    if (anchor_stamp[TIME_BITS-1] || $signed(pts) < $signed(anchor_stamp))
                    begin
                        anchor_stamp = pts;
                        anchor_wall  = wall_now;
                        if (warm_end == '0)
                            warm_end = wall_now + TIME_BITS'(cfg_warm);
                    end
                    if ($signed(wall_now) < $signed(warm_end))
                    begin
                        anchor_stamp = pts;
                        anchor_wall  = wall_now;
                    end
                    else
                    begin
                        lag = wall_now - (anchor_wall + (pts - anchor_stamp));
                        // Pull the reference earlier on early arrival
                        if (lag[TIME_BITS-1])
                        begin
                            anchor_wall = anchor_wall + lag;
                            lag = '0;
                        end
                    end
                end
                if (lag > TIME_BITS'(cfg_reset))
                begin
                    fate.act = ACT_FLUSH;
                    flush = 1'b1;
                end
                else if (lag > TIME_BITS'(cfg_render))
                begin
                    if (late_cnt != '1)
                        late_cnt++;
                    fate.act = ACT_DROP_LATE;
                end
                else if (display_taken)
                begin
                    if (busy_cnt != '1)
                        busy_cnt++;
                    fate.act = ACT_DROP_BUSY;
                end
                else
                begin
                    display_taken = 1'b1;
                    fate.act = ACT_RENDER;
                end
            end
            default:
                ;
        endcase
        fate.lag   = lag[ARRIVAL_BITS-1:0];
        fate.stamp = last_stamp;
        fate.late  = late_cnt;
        fate.busy  = busy_cnt;
        if (flush)
            restart_session();
        return fate;
    endfunction

    function automatic logic [ARRIVAL_BITS-1:0] rand_arrival();
        return ARRIVAL_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [STAMP_BITS-1:0] rand_stamp();
        return STAMP_BITS'({$urandom, $urandom});
    endfunction

    // Arrival offset around the nominal frame time: mostly on time, some late, a few early
    function automatic longint pick_delay();
        int dice;
        dice = $urandom_range(99);
        if (dice < 65)
            return $urandom_range(40);
        if (dice < 80)
            return $urandom_range(cfg_render + 200);
        if (dice < 83)
            return longint'(cfg_reset) + $urandom_range(1, 2000);
        if (dice < 95)
            return -longint'($urandom_range(1, 300));
        return $urandom_range(cfg_reset + 100);
    endfunction

    // Present one transaction, hold it until accepted, then log its fate
    task automatic send_item(cmd_t cmd, logic [ARRIVAL_BITS-1:0] arr, logic has_stamp,
                             logic [STAMP_BITS-1:0] raw);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        arrival_ms  <= arr;
        stamp_valid <= has_stamp;
        raw_stamp   <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        expected_fates.push_back(predict_frame_fate(cmd, arr, has_stamp, raw));
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_fates.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RENDER_LAG: cfg_render = data[LIMIT_BITS-1:0];
            CFG_RESET_LAG:  cfg_reset  = data[LIMIT_BITS-1:0];
            CFG_WARMUP:     cfg_warm   = data[LIMIT_BITS-1:0];
            CFG_TB_NUM:     cfg_num    = data[NUM_BITS-1:0];
            CFG_TB_DEN:     cfg_den    = data[DEN_BITS-1:0];
            default:        ;
        endcase
    endtask

    // Write every register; upper data bits of narrow registers carry junk
    task automatic set_config(logic [LIMIT_BITS-1:0] render, logic [LIMIT_BITS-1:0] flush_lag,
                              logic [LIMIT_BITS-1:0] warm, logic [NUM_BITS-1:0] num,
                              logic [DEN_BITS-1:0] den);
        write_reg(CFG_RENDER_LAG, {16'($urandom), render});
        write_reg(CFG_RESET_LAG, {16'($urandom), flush_lag});
        write_reg(CFG_WARMUP, {16'($urandom), warm});
        write_reg(CFG_TB_NUM, {16'($urandom), num});
        write_reg(CFG_TB_DEN, den);
    endtask

    // Play a stream of frames paced by the time base, mixed with commands and noise
    task automatic run_stream(int count);
        longint                  den_eff;
        longint                  num_eff;
        longint                  raw_step;
        longint                  ms_step;
        longint                  wall;
        int                      roll;
        logic                    in_seq;
        cmd_t                    cmd;
        logic                    has_stamp;
        logic [ARRIVAL_BITS-1:0] arr;
        logic [STAMP_BITS-1:0]   raw;
        den_eff  = (cfg_den == '0) ? 1 : longint'(cfg_den);
        num_eff  = (cfg_num == '0) ? 1 : longint'(cfg_num);
        raw_step = (FRAME_PERIOD * den_eff) / (longint'(MS_PER_S) * num_eff);
        if (raw_step == 0)
            raw_step = 1;
        ms_step = (raw_step * MS_PER_S * longint'(cfg_num)) / den_eff;
        stream_wall = longint'({$urandom_range(255), $urandom});
        stream_raw  = longint'($signed($urandom));
        send_item(CMD_START, rand_arrival(), 1'($urandom_range(1)), rand_stamp());
        for (int i = 1; i < count; i++)
        begin
            roll      = $urandom_range(99);
            cmd       = CMD_FRAME;
            has_stamp = 1'b1;
            arr       = rand_arrival();
            raw       = rand_stamp();
            in_seq    = 1'b1;
            wall      = stream_wall;
            if (roll < 55)
            begin
                stream_raw  += raw_step;
                stream_wall += ms_step;
                wall = stream_wall + pick_delay();
            end
            else if (roll < 75)
            begin
                cmd       = CMD_CONSUMED;
                has_stamp = 1'($urandom_range(1));
                in_seq    = 1'b0;
            end
            else if (roll < 80)
            begin
                has_stamp    = 1'b0;
                stream_wall += ms_step;
                wall = stream_wall;
            end
            else if (roll < 84)
            begin
                // Step the stamp backward to force a rebase
                stream_raw  -= raw_step * $urandom_range(1, 20);
                stream_wall += ms_step;
                wall = stream_wall + pick_delay();
            end
            else if (roll < 86)
            begin
                // Jump the stamp ahead of the wall clock
                stream_raw += raw_step * $urandom_range(2, 60);
            end
            else if (roll < 87)
            begin
                cmd       = CMD_START;
                has_stamp = 1'($urandom_range(1));
                in_seq    = 1'b0;
            end
            else if (roll < 90)
            begin
                cmd       = CMD_UNUSED;
                has_stamp = 1'($urandom_range(1));
                in_seq    = 1'b0;
            end
            else
            begin
                has_stamp = 1'($urandom_range(1));
                in_seq    = 1'b0;
            end
            if (in_seq)
            begin
                arr = (wall < 0) ? '0 : ARRIVAL_BITS'(wall);
                if (has_stamp)
                    raw = STAMP_BITS'(stream_raw);
            end
            send_item(cmd, arr, has_stamp, raw);
        end
    endtask

    task automatic test_directed();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        // Reset configuration: first frame rebases and arms warm-up, second finds display busy
        send_item(CMD_FRAME, 47'd1000, 1'b1, 48'd90000);
        send_item(CMD_FRAME, 47'd1033, 1'b1, 48'd93000);
        send_item(CMD_CONSUMED, rand_arrival(), 1'b1, rand_stamp());
        send_item(CMD_FRAME, 47'd1066, 1'b0, rand_stamp());
        send_item(CMD_UNUSED, rand_arrival(), 1'b1, rand_stamp());
        send_item(CMD_START, rand_arrival(), 1'b0, rand_stamp());
        // No warm-up: late, early pull, backward rebase, flush, negative stamp
        wait_drain();
        write_reg(CFG_WARMUP, '0);
        send_item(CMD_FRAME, 47'd10000, 1'b1, 48'd90000);
        send_item(CMD_CONSUMED, rand_arrival(), 1'b0, rand_stamp());
        send_item(CMD_FRAME, 47'd11400, 1'b1, 48'd180000);
        send_item(CMD_FRAME, 47'd12000, 1'b1, 48'd270000);
        send_item(CMD_FRAME, 47'd12500, 1'b1, 48'd360000);
        send_item(CMD_CONSUMED, rand_arrival(), 1'b1, rand_stamp());
        send_item(CMD_FRAME, 47'd13000, 1'b1, 48'd0);
        send_item(CMD_FRAME, 47'd40000, 1'b1, 48'd900000);
        send_item(CMD_FRAME, 47'd40100, 1'b1, 48'd900000);
        send_item(CMD_FRAME, 47'd41000, 1'b1, -48'sd90000);
        send_item(CMD_FRAME, ARRIVAL_MAX, 1'b1, 48'd9000);
        send_item(CMD_FRAME, '0, 1'b1, 48'd9000);
        // Zero limits and the widest time base: stamps saturate both ways
        wait_drain();
        set_config('0, '0, '1, '1, DEN_BITS'(1));
        send_item(CMD_FRAME, 47'd5000, 1'b1, STAMP_MAX);
        send_item(CMD_FRAME, 47'd5000, 1'b1, STAMP_MIN);
        send_item(CMD_FRAME, 47'd5000, 1'b1, '1);
        // Zero numerator, zero denominator, write to an index past the register list
        wait_drain();
        write_reg(CFG_TB_NUM, '0);
        send_item(CMD_FRAME, 47'd6000, 1'b1, rand_stamp());
        wait_drain();
        write_reg(CFG_TB_NUM, CFG_DATA_BITS'(1));
        write_reg(CFG_TB_DEN, '0);
        write_reg(CFG_INDEX_BITS'($urandom_range(CFG_TB_DEN + 1, (1 << CFG_INDEX_BITS) - 1)),
                  $urandom);
        send_item(CMD_FRAME, 47'd6000, 1'b1, 48'd7);
    endtask

    task automatic test_slow_receiver();
        wait_drain();
        send_gap_pct   = 10;
        recv_stall_pct = 85;
        set_config(LIMIT_BITS'(300), LIMIT_BITS'(5000), LIMIT_BITS'(200), NUM_BITS'(1),
                   DEN_BITS'(90000));
        run_stream(550);
    endtask

    task automatic test_slow_sender();
        wait_drain();
        send_gap_pct   = 85;
        recv_stall_pct = 10;
        set_config(LIMIT_BITS'(20), '1, '0, NUM_BITS'(1), DEN_BITS'(1000));
        run_stream(550);
    endtask

    // Random limits and time base at full rate, with one full drain midway
    task automatic test_back_to_back();
        logic [LIMIT_BITS-1:0] render;
        wait_drain();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        render = LIMIT_BITS'($urandom_range(50, 400));
        set_config(render, render + LIMIT_BITS'($urandom_range(100, 3000)),
                   LIMIT_BITS'($urandom_range(500)), NUM_BITS'($urandom_range(1, 65535)),
                   DEN_BITS'($urandom));
        run_stream(250);
        wait_drain();
        run_stream(250);
    endtask

    task automatic test_extreme_timebase();
        wait_drain();
        set_config('0, '1, LIMIT_BITS'(100), '1, DEN_BITS'(1));
        run_stream(60);
        wait_drain();
        set_config('1, '1, '1, NUM_BITS'(1), '1);
        run_stream(60);
    endtask

    // Random receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each result with the oldest expected fate
    always @(posedge clk)
    begin : check_results
        frame_fate_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fates.size() == 0)
            begin
                $error("result transaction with nothing expected: action %0d", action);
                mismatch_count++;
            end
            else
            begin
                want = expected_fates.pop_front();
                if (action !== want.act)
                begin
                    $error("action: expected %0d, got %0d", want.act, action);
                    mismatch_count++;
                end
                if (lag_ms !== want.lag)
                begin
                    $error("lag_ms: expected %0d, got %0d", want.lag, lag_ms);
                    mismatch_count++;
                end
                if (stamp_ms !== want.stamp)
                begin
                    $error("stamp_ms: expected %0d, got %0d", $signed(want.stamp), stamp_ms);
                    mismatch_count++;
                end
                if (late_drops !== want.late)
                begin
                    $error("late_drops: expected %0d, got %0d", want.late, late_drops);
                    mismatch_count++;
                end
                if (busy_drops !== want.busy)
                begin
                    $error("busy_drops: expected %0d, got %0d", want.busy, busy_drops);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        restart_session();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_slow_receiver();
        test_slow_sender();
        test_back_to_back();
        test_extreme_timebase();
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (expected_fates.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_fates.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
